// ----- sv/ks_pkg.sv -----
package ks_pkg;

  // Field widths of the item and result words.
  localparam int WEIGHT_W = 8;
  localparam int IN_VALUE_W = 8;
  localparam int VALUE_W = 13;
  localparam int IDX_W = 5;
  localparam int CAP_W = 8;

  // Table entries saturate at the largest 13-bit value.
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // A solve emits at most this many result words.
  localparam int RESULT_CAP = 32;
  localparam int KW = $clog2(RESULT_CAP + 1);

  // Register port geometry.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  // Solver sequencer states.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FILL    = 6'b000010,
    S_BT_INIT = 6'b000100,
    S_BT_RD   = 6'b001000,
    S_BT_EVAL = 6'b010000,
    S_FINISH  = 6'b100000
  } ks_state_t;

endpackage

// ----- sv/ks_if.sv -----
// Item channel: weight, value and end-of-set mark.
interface ks_in_if import ks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WEIGHT_W-1:0]   item_weight;
  logic [IN_VALUE_W-1:0] item_value;
  logic                  item_last;

  modport source (output valid, item_weight, item_value, item_last, input ready);
  modport sink (input valid, item_weight, item_value, item_last, output ready);
endinterface

// Result channel: one word per chosen item, or a single none-chosen word.
interface ks_out_if import ks_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   chosen_index;
  logic               chosen_valid;
  logic [VALUE_W-1:0] best_value;
  logic               overflowed;
  logic               result_last;

  modport source (output valid, chosen_index, chosen_valid, best_value, overflowed,
                  result_last, input ready);
  modport sink (input valid, chosen_index, chosen_valid, best_value, overflowed,
                result_last, output ready);
endinterface

// ----- sv/ks_cfg_regs.sv -----
module ks_cfg_regs import ks_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  capacity
);

  logic [CAP_W-1:0] capacity_r;
  logic             hit_cap;

  // Word select; the low address bits pick a byte lane and are not decoded.
  assign hit_cap = (paddr[2] == REG_CAPACITY);

  // Capacity register, written in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (psel && penable && pwrite && hit_cap) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read back; addresses beyond the register list read as zero.
  assign prdata   = hit_cap ? {{(DATA_W-CAP_W){1'b0}}, capacity_r} : '0;
  assign pready   = 1'b1;
  assign capacity = capacity_r;

endmodule

// ----- sv/ks_solver.sv -----
module ks_solver import ks_pkg::*; #(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] capacity,
  ks_in_if.sink            in_if,
  ks_out_if.source         out_if
);

  localparam int CW = $clog2(MAX_CAPACITY + 1);
  localparam int RW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int XW = ((CW > WEIGHT_W) ? CW : WEIGHT_W) + 1;
  localparam int TDEPTH = 2 ** (RW + CW);
  localparam int WDEPTH = 2 ** RW;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_CAPACITY);
  localparam logic [NW-1:0] ITEMS_LIM = NW'(MAX_ITEMS);
  localparam logic [KW-1:0] K_LIM = KW'(RESULT_CAP);

  // Table memory: row-major, row in the upper address bits.
  logic [VALUE_W-1:0]  tbl_mem [TDEPTH];
  logic [RW+CW-1:0]    ta_addr;
  logic [RW+CW-1:0]    tb_addr;
  logic [RW+CW-1:0]    t_waddr;
  logic                t_rd_en;
  logic                t_we;
  logic [VALUE_W-1:0]  t_wdata;
  logic [VALUE_W-1:0]  ta_q_r;
  logic [VALUE_W-1:0]  tb_q_r;

  // Weight memory, one entry per held item.
  logic [WEIGHT_W-1:0] wgt_mem [WDEPTH];
  logic [RW-1:0]       w_waddr;
  logic [RW-1:0]       w_raddr;
  logic                w_we;
  logic                w_rd_en;
  logic [WEIGHT_W-1:0] w_q_r;

  // Sequencer and item state.
  ks_state_t             state_r;
  logic [NW-1:0]         item_cnt_r;
  logic                  drop_r;
  logic [WEIGHT_W-1:0]   wt_r;
  logic [IN_VALUE_W-1:0] val_r;
  logic                  last_r;
  logic [RW-1:0]         row_r;
  logic                  first_row_r;

  // Row fill: read issue column and the write-back stage.
  logic [CW-1:0] iss_col_r;
  logic          iss_on_r;
  logic          p_vld_r;
  logic [CW-1:0] p_col_r;
  logic          p_take_r;

  // Backtrack state.
  logic [NW-1:0]      bt_i_r;
  logic [CW-1:0]      bt_w_r;
  logic               bt_first_r;
  logic [VALUE_W-1:0] best_r;
  logic               pend_vld_r;
  logic [IDX_W-1:0]   pend_idx_r;
  logic [KW-1:0]      k_r;

  // Output register.
  logic               ov_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic               o_cv_r;
  logic [VALUE_W-1:0] o_best_r;
  logic               o_ovf_r;
  logic               o_last_r;

  logic               in_fire;
  logic               out_free;
  logic               out_load;
  logic               room;
  logic [RW-1:0]      prev_row;
  logic [CW-1:0]      col_minus;
  logic [VALUE_W-1:0] skip_v;
  logic [VALUE_W-1:0] take_b;
  logic [VALUE_W:0]   fill_sum;
  logic [VALUE_W-1:0] take_v;
  logic [VALUE_W-1:0] fill_best;
  logic [VALUE_W-1:0] bt_tb;
  logic               bt_hit;
  logic [IDX_W-1:0]   bt_idx;
  logic [CW-1:0]      bt_w_next;
  logic               bt_stall;
  logic               bt_done;
  logic [CW-1:0]      cap_eff;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !ov_r || out_if.ready;
  assign room        = (item_cnt_r < ITEMS_LIM);

  // Fill reads come from the previous row; column minus weight is only used when in range.
  assign prev_row  = row_r - RW'(1);
  assign col_minus = CW'(XW'(iss_col_r) - XW'(wt_r));

  // Table port addresses: fill reads row above, backtrack reads rows i and i-1.
  always_comb begin
    if (state_r == S_FILL) begin
      ta_addr = {prev_row, iss_col_r};
      tb_addr = {prev_row, col_minus};
    end else begin
      ta_addr = {RW'(bt_i_r - NW'(1)), bt_w_r};
      tb_addr = {RW'(bt_i_r - NW'(2)), bt_w_r};
    end
  end

  assign t_rd_en = ((state_r == S_FILL) && iss_on_r) || (state_r == S_BT_RD);

  // Best of skipping or taking the item; the first row sees an all-zero row above.
  assign skip_v    = first_row_r ? '0 : ta_q_r;
  assign take_b    = first_row_r ? '0 : tb_q_r;
  assign fill_sum  = {1'b0, take_b} + {{(VALUE_W + 1 - IN_VALUE_W){1'b0}}, val_r};
  assign take_v    = fill_sum[VALUE_W] ? VALUE_MAX : fill_sum[VALUE_W-1:0];
  assign fill_best = (p_col_r == '0) ? '0 :
                     (p_take_r && (take_v > skip_v)) ? take_v : skip_v;

  assign t_we    = (state_r == S_FILL) && p_vld_r;
  assign t_waddr = {row_r, p_col_r};
  assign t_wdata = fill_best;

  // Weights are stored as items arrive and read back during the backtrack.
  assign w_we    = in_fire && room;
  assign w_waddr = RW'(item_cnt_r);
  assign w_raddr = RW'(bt_i_r - NW'(1));
  assign w_rd_en = (state_r == S_BT_RD);

  // Backtrack step: item i was taken when its row differs from the row below.
  assign bt_tb     = (bt_i_r == NW'(1)) ? '0 : tb_q_r;
  assign bt_hit    = (ta_q_r != bt_tb);
  assign bt_idx    = IDX_W'(bt_i_r - NW'(1));
  assign bt_w_next = (XW'(w_q_r) <= XW'(bt_w_r)) ? CW'(XW'(bt_w_r) - XW'(w_q_r)) : '0;
  assign bt_stall  = bt_hit && pend_vld_r && !out_free;
  assign bt_done   = (bt_i_r == NW'(1)) || (bt_hit && ((k_r + KW'(1)) == K_LIM));

  // The output register loads when a held pick is pushed out or the final word is formed.
  assign out_load = ((state_r == S_BT_EVAL) && !bt_stall && bt_hit && pend_vld_r) ||
                    ((state_r == S_FINISH) && out_free);

  // Capacity clamps to the last table column.
  assign cap_eff = (XW'(capacity) > XW'(COL_LAST)) ? COL_LAST : CW'(capacity);

  // Table memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (t_we) begin
      tbl_mem[t_waddr] <= t_wdata;
    end
    if (t_rd_en) begin
      ta_q_r <= tbl_mem[ta_addr];
      tb_q_r <= tbl_mem[tb_addr];
    end
  end

  // Weight memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (w_we) begin
      wgt_mem[w_waddr] <= in_if.item_weight;
    end
    if (w_rd_en) begin
      w_q_r <= wgt_mem[w_raddr];
    end
  end

  // Sequencer, fill pipeline, backtrack and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      item_cnt_r <= '0;
      drop_r     <= 1'b0;
      iss_on_r   <= 1'b0;
      p_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_if.ready) begin
        ov_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            wt_r   <= in_if.item_weight;
            val_r  <= in_if.item_value;
            last_r <= in_if.item_last;
            if (room) begin
              row_r       <= RW'(item_cnt_r);
              first_row_r <= (item_cnt_r == '0);
              item_cnt_r  <= item_cnt_r + NW'(1);
              iss_col_r   <= '0;
              iss_on_r    <= 1'b1;
              p_vld_r     <= 1'b0;
              state_r     <= S_FILL;
            end else begin
              drop_r <= 1'b1;
              if (in_if.item_last) begin
                state_r <= S_BT_INIT;
              end
            end
          end
        end

        S_FILL: begin
          // Issue one column read a cycle; the write lands in the following cycle.
          if (iss_on_r) begin
            if (iss_col_r == COL_LAST) begin
              iss_on_r <= 1'b0;
            end else begin
              iss_col_r <= iss_col_r + CW'(1);
            end
          end
          p_vld_r  <= iss_on_r;
          p_col_r  <= iss_col_r;
          p_take_r <= (XW'(wt_r) <= XW'(iss_col_r));
          if (p_vld_r && (p_col_r == COL_LAST)) begin
            state_r <= last_r ? S_BT_INIT : S_IDLE;
          end
        end

        S_BT_INIT: begin
          bt_i_r     <= item_cnt_r;
          bt_w_r     <= cap_eff;
          bt_first_r <= 1'b1;
          pend_vld_r <= 1'b0;
          k_r        <= '0;
          if (item_cnt_r == '0) begin
            best_r  <= '0;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_BT_RD;
          end
        end

        S_BT_RD: begin
          state_r <= S_BT_EVAL;
        end

        S_BT_EVAL: begin
          // A new pick pushes the one held before it; hold while the output is full and a push is due.
          if (!bt_stall) begin
            if (bt_first_r) begin
              best_r     <= ta_q_r;
              bt_first_r <= 1'b0;
            end
            if (bt_hit) begin
              if (pend_vld_r) begin
                o_idx_r  <= pend_idx_r;
                o_cv_r   <= 1'b1;
                o_best_r <= best_r;
                o_ovf_r  <= drop_r;
                o_last_r <= 1'b0;
              end
              pend_vld_r <= 1'b1;
              pend_idx_r <= bt_idx;
              k_r        <= k_r + KW'(1);
              bt_w_r     <= bt_w_next;
            end
            bt_i_r  <= bt_i_r - NW'(1);
            state_r <= bt_done ? S_FINISH : S_BT_RD;
          end
        end

        S_FINISH: begin
          // Final word: the held pick, or a single none-chosen word.
          if (out_free) begin
            o_idx_r    <= pend_vld_r ? pend_idx_r : '0;
            o_cv_r     <= pend_vld_r;
            o_best_r   <= best_r;
            o_ovf_r    <= drop_r;
            o_last_r   <= 1'b1;
            pend_vld_r <= 1'b0;
            item_cnt_r <= '0;
            drop_r     <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.chosen_index = o_idx_r;
  assign out_if.chosen_valid = o_cv_r;
  assign out_if.best_value   = o_best_r;
  assign out_if.overflowed   = o_ovf_r;
  assign out_if.result_last  = o_last_r;

endmodule

// ----- sv/knapsack_item_selector_top.sv -----
// 0/1 knapsack solver. Items arrive one word at a time on in_if; each held item fills one
// row of a dynamic-programming table over every column 0 to MAX_CAPACITY, one column a
// cycle through the table memory, whose two read ports fetch the skip and take entries of
// the row above; the block takes no new item until the row is written. An item that
// arrives when MAX_ITEMS are already held is dropped and flagged in overflowed. The word
// marked item_last starts the solve with the capacity register (clamped to MAX_CAPACITY):
// for each held item it examines, the backtrack first reads the table and weight memories
// and then compares, and it waits while the result side stalls. Chosen indices come out in
// decreasing order, at most 32 of them, the final word carrying result_last; an empty
// choice gives one word with chosen_valid low.
// The table memory holds no reset contents and needs no clearing pass after reset.
module knapsack_item_selector_top import ks_pkg::*; #(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  ks_in_if.sink             in_if,
  ks_out_if.source          out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CAP_W-1:0] capacity;

  // Register port.
  ks_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Table fill and backtrack.
  ks_solver #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_solver (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity),
    .in_if    (in_if),
    .out_if   (out_if)
  );

endmodule

// ----- sv/ks_checker.sv -----
module ks_checker import ks_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IDX_W-1:0]   chosen_index,
  input logic               chosen_valid,
  input logic [VALUE_W-1:0] best_value,
  input logic               overflowed,
  input logic               result_last
);

  // The result register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chosen_index) &&
    $stable(chosen_valid) && $stable(best_value) && $stable(overflowed) &&
    $stable(result_last))
    else $error("stalled result word changed");

  // The none-chosen word is the only word of its solve and carries index zero.
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !chosen_valid |-> result_last && (chosen_index == '0))
    else $error("malformed none-chosen word");

  // Any chosen item means the optimum is above zero.
  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && chosen_valid |-> (best_value != '0))
    else $error("item chosen with zero best value");

endmodule

bind knapsack_item_selector_top ks_checker u_ks_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .chosen_index (out_if.chosen_index),
  .chosen_valid (out_if.chosen_valid),
  .best_value   (out_if.best_value),
  .overflowed   (out_if.overflowed),
  .result_last  (out_if.result_last)
);

// ----- test/knapsack_selection_checker.sv -----
// Watches the item, result and register ports, keeps its own copy of the
// knapsack table and predicts every result word of each solve.
module knapsack_selection_checker import ks_pkg::*; #(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  ks_in_if                  item_mon,
  ks_out_if                 pick_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                words_due
);

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               chosen;
    logic [VALUE_W-1:0] total;
    logic               ovf;
    logic               last_word;
  } pick_word_t;

  // Best value per held item (row) and capacity (column).
  logic [VALUE_W-1:0]  row_best [MAX_ITEMS][MAX_CAPACITY+1];
  logic [WEIGHT_W-1:0] held_weight [MAX_ITEMS];
  int                  held_items;
  bit                  dropped_any;
  logic [CAP_W-1:0]    capacity_reg;
  pick_word_t          due_words[$];
  int                  mismatches = 0;

  // Row 0 stands for the empty set and is zero everywhere.
  function automatic int best_at(int row, int col);
    if (row == 0) return 0;
    return int'(row_best[row-1][col]);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  // Fill the new item's row, and on the closing item backtrack the choice.
  task automatic absorb_item(logic [WEIGHT_W-1:0] wt, logic [IN_VALUE_W-1:0] val, logic closes);
    int col;
    int skip;
    int take;
    int total;
    int found;
    int i;
    pick_word_t word;
    if (held_items < MAX_ITEMS) begin
      held_weight[held_items] = wt;
      held_items++;
      for (col = 0; col <= MAX_CAPACITY; col++) begin
        skip = best_at(held_items - 1, col);
        if (col > 0 && int'(wt) <= col) begin
          take = best_at(held_items - 1, col - int'(wt)) + int'(val);
          if (take > int'(VALUE_MAX)) take = int'(VALUE_MAX);
          if (take > skip) skip = take;
        end
        row_best[held_items-1][col] = VALUE_W'(skip);
      end
    end else begin
      dropped_any = 1'b1;
    end
    if (!closes) return;

    col = (int'(capacity_reg) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity_reg);
    total = best_at(held_items, col);
    found = 0;
    for (i = held_items; i > 0 && found < RESULT_CAP; i--) begin
      if (best_at(i, col) != best_at(i - 1, col)) begin
        word = '{idx: IDX_W'(i - 1), chosen: 1'b1, total: VALUE_W'(total),
                 ovf: dropped_any, last_word: 1'b0};
        due_words = {due_words, word};
        found++;
        col = (int'(held_weight[i-1]) <= col) ? col - int'(held_weight[i-1]) : 0;
      end
    end
    // An empty choice still yields one word, with chosen low.
    if (found == 0) begin
      word = '{idx: '0, chosen: 1'b0, total: VALUE_W'(total), ovf: dropped_any,
               last_word: 1'b1};
      due_words = {due_words, word};
    end else begin
      due_words[due_words.size()-1].last_word = 1'b1;
    end
    held_items = 0;
    dropped_any = 1'b0;
  endtask

  task automatic compare_word(pick_word_t seen);
    pick_word_t want;
    if (due_words.size() == 0) begin
      $error("result word with no expectation: chosen_index %0d", seen.idx);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    check_field("chosen_index", 16'(want.idx), 16'(seen.idx));
    check_field("chosen_valid", 16'(want.chosen), 16'(seen.chosen));
    check_field("best_value", 16'(want.total), 16'(seen.total));
    check_field("overflowed", 16'(want.ovf), 16'(seen.ovf));
    check_field("result_last", 16'(want.last_word), 16'(seen.last_word));
  endtask

  // Results are checked before new items are folded in at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_items = 0;
      dropped_any = 1'b0;
      capacity_reg = '0;
      due_words.delete();
    end else begin
      if (pick_mon.valid && pick_mon.ready)
        compare_word('{idx: pick_mon.chosen_index, chosen: pick_mon.chosen_valid,
                       total: pick_mon.best_value, ovf: pick_mon.overflowed,
                       last_word: pick_mon.result_last});
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        capacity_reg = pwdata[CAP_W-1:0];
      if (item_mon.valid && item_mon.ready)
        absorb_item(item_mon.item_weight, item_mon.item_value, item_mon.item_last);
    end
    words_due <= due_words.size();
    fail_count <= mismatches;
  end

endmodule

// ----- test/knapsack_item_selector_top_tb.sv -----
module knapsack_item_selector_top_tb;
  import ks_pkg::*;

  localparam int MAX_ITEMS     = 32;
  localparam int MAX_CAPACITY  = 255;
  localparam int SETTLE_CYCLES = MAX_CAPACITY + 40;
  localparam int TARGET_ITEMS  = 370;
  localparam int RUN_LIMIT     = 5_000_000;

  typedef enum int {SET_SHORT, SET_LONG, SET_OVER, SET_FULL, SET_NOISE} set_kind_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]   weight;
    logic [IN_VALUE_W-1:0] worth;
    logic                  closes;
  } item_word_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                words_due;

  ks_in_if  item_ch ();
  ks_out_if pick_ch ();

  item_word_t item_queue[$];
  int         items_built = 0;
  int         hold_len = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;

  knapsack_item_selector_top #(.MAX_ITEMS(MAX_ITEMS), .MAX_CAPACITY(MAX_CAPACITY)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (item_ch),
    .out_if  (pick_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  knapsack_selection_checker #(.MAX_ITEMS(MAX_ITEMS), .MAX_CAPACITY(MAX_CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_mon   (item_ch),
    .pick_mon   (pick_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic queue_item(int wt, int val, bit closes);
    item_word_t it;
    it = '{weight: WEIGHT_W'(wt), worth: IN_VALUE_W'(val), closes: closes};
    item_queue = {item_queue, it};
    items_built++;
  endtask

  // Build one set of items; the shape of the weights varies per set.
  task automatic queue_set(set_kind_t kind, int cap);
    int len;
    int mode;
    int wt;
    int val;
    int i;
    mode = $urandom_range(0, 3);
    case (kind)
      SET_LONG: len = $urandom_range(20, MAX_ITEMS);
      SET_OVER: len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      SET_FULL: len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS);
      SET_NOISE: len = $urandom_range(1, 6);
      default: len = $urandom_range(1, 10);
    endcase
    for (i = 0; i < len; i++) begin
      val = $urandom_range(0, 255);
      if (kind == SET_FULL) begin
        wt = 0;
        val = $urandom_range(1, 255);
      end else if (kind == SET_NOISE || mode == 0) begin
        wt = $urandom_range(0, 255);
      end else if (mode == 1) begin
        wt = $urandom_range(0, cap / 4 + 1);
      end else if (mode == 2) begin
        wt = $urandom_range(0, 15);
      end else begin
        wt = $urandom_range(0, 1) ? 255 : 0;
      end
      queue_item(wt, val, i == len - 1);
    end
  endtask

  function automatic set_kind_t draw_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return SET_SHORT;
    if (r == 6) return SET_LONG;
    if (r == 7) return SET_OVER;
    if (r == 8) return SET_FULL;
    return SET_NOISE;
  endfunction

  // Offer every queued item, with a random gap before each word outside quiet phases.
  task automatic offer_items();
    item_word_t it;
    int gap;
    while (item_queue.size() > 0) begin
      it = item_queue.pop_front();
      gap = tx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item_ch.valid <= 1'b1;
      item_ch.item_weight <= it.weight;
      item_ch.item_value <= it.worth;
      item_ch.item_last <= it.closes;
      do @(posedge clk); while (item_ch.ready !== 1'b1);
    end
    item_ch.valid <= 1'b0;
  endtask

  // Wait for every predicted word, then for a row fill that yields no word.
  task automatic settle();
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(int cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int stall;
    pick_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        pick_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        pick_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pick_ch.ready <= 1'b1;
      do @(posedge clk); while (pick_ch.valid !== 1'b1);
    end
  end

  initial begin
    int phase;
    int cap;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.item_weight = '0;
    item_ch.item_value = '0;
    item_ch.item_last = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small capacity: a plain set, a lone heavy item, and extreme fields.
    write_capacity(10);
    queue_item(3, 5, 0);
    queue_item(4, 6, 0);
    queue_item(5, 7, 1);
    queue_item(200, 100, 1);
    queue_item(0, 255, 0);
    queue_item(255, 255, 0);
    queue_item(0, 0, 0);
    queue_item(10, 0, 1);
    offer_items();
    settle();

    // Largest capacity with an item exactly that heavy.
    write_capacity(255);
    queue_item(255, 255, 0);
    queue_item(1, 1, 0);
    queue_item(254, 254, 1);
    offer_items();
    settle();

    // Zero capacity: no item can be taken, not even a weightless one.
    write_capacity(0);
    queue_item(0, 7, 0);
    queue_item(1, 9, 0);
    queue_item(0, 0, 1);
    offer_items();
    settle();

    // Capacity changed while a set is half delivered; the solve uses the new one.
    queue_item(5, 50, 0);
    queue_item(2, 9, 0);
    offer_items();
    settle();
    write_capacity(7);
    queue_item(3, 20, 1);
    queue_item(4, 0, 0);
    queue_item(9, 0, 1);
    offer_items();
    settle();

    // Random phases, each with its own capacity and idling pattern.
    phase = 0;
    while (items_built < TARGET_ITEMS) begin
      case (phase)
        0: cap = 255;
        1: cap = 0;
        default: begin
          case ($urandom_range(0, 3))
            0: cap = 255;
            1: cap = $urandom_range(1, 30);
            default: cap = $urandom_range(0, 255);
          endcase
        end
      endcase
      tx_quiet = (phase % 4 == 3);
      rx_quiet = (phase % 5 == 4);
      write_capacity(cap);
      if (phase == 2) begin
        // Long result stall while the next set is already being offered.
        hold_len = 2500;
        queue_set(SET_FULL, cap);
        queue_set(SET_FULL, cap);
        queue_set(SET_SHORT, cap);
      end else begin
        repeat (3) queue_set(draw_kind(), cap);
      end
      offer_items();
      settle();
      phase++;
    end

    if (fail_count == 0 && words_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ks_pkg.sv
sv/ks_if.sv
sv/ks_cfg_regs.sv
sv/ks_solver.sv
sv/knapsack_item_selector_top.sv
sv/ks_checker.sv
test/knapsack_selection_checker.sv
test/knapsack_item_selector_top_tb.sv
